// ===== sv/bsfh_pkg.sv =====
// Shared constants, types and helper functions for the FNV-1a / fmix64 hasher.
package bsfh_pkg;

  localparam logic [63:0] FNV_OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] MIX_MUL_A        = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] MIX_MUL_B        = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] MIX_SEED         = 64'ha076_1d64_78bd_642f;
  localparam int unsigned MIX_SHIFT        = 33;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MIX  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Partial product selected in one multiply step (low 64 bits of a 64x64 product).
  typedef enum logic [1:0] {
    PH_LL = 2'd0,  // a_lo * b_lo
    PH_LH = 2'd1,  // a_lo * b_hi, upper half
    PH_HL = 2'd2   // a_hi * b_lo, upper half, then xor-shift
  } phase_t;

  // Multiply constant selector.
  typedef enum logic {
    MUL_SEL_A = 1'b0,
    MUL_SEL_B = 1'b1
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take;      // input transfer this cycle
    logic     mix_en;    // run one multiply step
    phase_t   phase;
    mul_sel_t mul_sel;
    logic     out_load;  // copy finished hash into the output register
  } bsfh_cmd_t;

  // One FNV-1a round: xor the byte in, multiply by 2^40 + 0x1b3.
  function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [63:0] xorshift33(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

// ===== sv/bsfh_ctrl.sv =====
// Controller: handshakes, finalize sequencing and output register valid.
module bsfh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_end_of_message,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bsfh_pkg::bsfh_cmd_t cmd
);
  import bsfh_pkg::*;

  state_t   state_r, state_nxt;
  phase_t   phase_r, phase_nxt;
  mul_sel_t mul_r, mul_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     take;
  logic     out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mul_nxt   = mul_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_end_of_message) begin
          state_nxt = ST_MIX;
          phase_nxt = PH_LL;
          mul_nxt   = MUL_SEL_A;
        end
      end
      ST_MIX: begin
        case (phase_r)
          PH_LL: phase_nxt = PH_LH;
          PH_LH: phase_nxt = PH_HL;
          PH_HL: begin
            phase_nxt = PH_LL;
            if (mul_r == MUL_SEL_B) begin
              mul_nxt   = MUL_SEL_A;
              state_nxt = ST_DONE;
            end else begin
              mul_nxt = MUL_SEL_B;
            end
          end
          default: phase_nxt = PH_LL;
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_LL;
      mul_r       <= MUL_SEL_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mul_r       <= mul_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.take     = take;
  assign cmd.mix_en   = (state_r == ST_MIX);
  assign cmd.phase    = phase_r;
  assign cmd.mul_sel  = mul_r;
  assign cmd.out_load = out_load;

  // A last item is followed by exactly six multiply steps before the result is ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_end_of_message) |-> ##7 (state_r == ST_DONE))
    else $error("finalize sequence length wrong");

  // The second multiply constant is only selected inside the mix sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mul_r == MUL_SEL_B) |-> (state_r == ST_MIX))
    else $error("multiply selector left set outside mix");

  // A loaded result is presented on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

  // No new input is taken while the finalizer is busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX) |-> !take)
    else $error("input taken during finalize");

endmodule

// ===== sv/bsfh_dp.sv =====
// Datapath: running FNV-1a state, shared 32x32 multiplier for fmix64, output register.
module bsfh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_data_byte,
  input  logic                in_no_byte,
  input  logic                in_end_of_message,
  input  bsfh_pkg::bsfh_cmd_t cmd,
  output logic [63:0]         out_hash_value
);
  import bsfh_pkg::*;

  logic [63:0] running_r, running_nxt;
  logic [63:0] mix_r, mix_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] hash_r;
  logic [63:0] absorbed;
  logic [63:0] final_in;
  logic [63:0] mul_const;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [63:0] acc_sum;

  assign absorbed = fnv_absorb(running_r, in_data_byte);
  assign final_in = in_no_byte ? running_r : absorbed;

  always_comb begin
    running_nxt = running_r;
    if (cmd.take) begin
      if (in_end_of_message) begin
        running_nxt = FNV_OFFSET_BASIS;
      end else if (!in_no_byte) begin
        running_nxt = absorbed;
      end
    end
  end

  assign mul_const = (cmd.mul_sel == MUL_SEL_B) ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    case (cmd.phase)
      PH_LL: begin
        op_a = mix_r[31:0];
        op_b = mul_const[31:0];
      end
      PH_LH: begin
        op_a = mix_r[31:0];
        op_b = mul_const[63:32];
      end
      PH_HL: begin
        op_a = mix_r[63:32];
        op_b = mul_const[31:0];
      end
      default: begin
        op_a = mix_r[31:0];
        op_b = mul_const[31:0];
      end
    endcase
  end

  assign prod    = op_a * op_b;
  assign acc_sum = acc_r + {prod[31:0], 32'd0};

  always_comb begin
    mix_nxt = mix_r;
    acc_nxt = acc_r;
    if (cmd.take && in_end_of_message) begin
      mix_nxt = xorshift33(final_in ^ MIX_SEED);
    end else if (cmd.mix_en) begin
      case (cmd.phase)
        PH_LL:   acc_nxt = prod;
        PH_LH:   acc_nxt = acc_sum;
        PH_HL:   mix_nxt = xorshift33(acc_sum);
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= FNV_OFFSET_BASIS;
    end else begin
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mix_r <= mix_nxt;
    acc_r <= acc_nxt;
    if (cmd.out_load) begin
      hash_r <= mix_r;
    end
  end

  assign out_hash_value = hash_r;

endmodule

// ===== sv/byte_stream_fnv_fmix_hasher.sv =====
// Top level of the streaming FNV-1a 64 hasher with seeded fmix64 finalizer.
//
// Usage:
//   Input channel (in_valid/in_ready): one message byte per transfer on
//   in_data_byte. in_no_byte marks a transfer without a byte (an empty
//   message is one transfer with in_no_byte and in_end_of_message both set).
//   in_end_of_message marks the last transfer of a message.
//   Output channel (out_valid/out_ready): one 64-bit out_hash_value per
//   message, in message order.
// Throughput: bytes stream at one per cycle while in_ready is high. A last
//   transfer blocks the input until the finalize is done: after it, the
//   fmix64 finalizer runs its two 64x64 constant multiplies as three 32x32
//   partial products each on one shared multiplier (ST_MIX), and then the
//   hash moves into the output register (ST_DONE).
// Result: out_valid is registered and rises once the hash has been loaded.
// Stall: while out_ready is low the result holds in the output register and
//   bytes of the next message are still taken; apart from the finalize, the
//   block only blocks input when a further finished hash has nowhere to go.
// Reset: rst_n (synchronous, active low) returns the running state to the
//   FNV offset basis and drops out_valid.
module byte_stream_fnv_fmix_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_no_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);
  import bsfh_pkg::*;

  bsfh_cmd_t cmd;

  // Sequence transfers and finalize steps.
  bsfh_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_end_of_message (in_end_of_message),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cmd               (cmd)
  );

  // Hold the running hash, run the mix and hold the result.
  bsfh_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_data_byte),
    .in_no_byte        (in_no_byte),
    .in_end_of_message (in_end_of_message),
    .cmd               (cmd),
    .out_hash_value    (out_hash_value)
  );

endmodule

// ===== tb/byte_stream_fnv_fmix_hasher_test.sv =====
// Self-checking testbench for the streaming FNV-1a 64 / seeded fmix64 byte hasher.
module byte_stream_fnv_fmix_hasher_test;
  import bsfh_pkg::*;

  // 1099511628211 = 2^40 + 0x1b3
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  localparam int unsigned PHASE_ITEMS      = 470;  // counted items per random phase
  localparam int unsigned LONG_HOLD_CYCLES = 300;  // receiver back-pressure burst
  localparam int unsigned TAIL_CYCLES      = 24;   // tail of the run with the output kept open
  localparam int unsigned DIRECTED_ROWS    = 18;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_no_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hash_value;

  // One input transfer of the directed part.
  typedef struct packed {
    logic [7:0] data;
    logic       no_byte;
    logic       eom;
  } stim_row_t;

  // Directed stimulus: empty messages, byte extremes, byte carried on the end
  // mark, byteless end mark, byteless filler inside a message, and messages
  // back to back. Each message's hash is checked against the predictor below.
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{8'h00, 1'b1, 1'b1},  // empty message
    '{8'h00, 1'b0, 1'b1},  // single zero byte
    '{8'hff, 1'b0, 1'b1},  // single all-ones byte
    '{8'ha5, 1'b1, 1'b0},  // byteless filler, no result
    '{8'hff, 1'b1, 1'b1},  // empty message with junk on the data lines
    '{8'h61, 1'b0, 1'b0},  // "abc", end mark on the last byte
    '{8'h62, 1'b0, 1'b0},
    '{8'h63, 1'b0, 1'b1},
    '{8'h00, 1'b0, 1'b0},  // two bytes, then a byteless end mark
    '{8'hff, 1'b0, 1'b0},
    '{8'h55, 1'b1, 1'b1},
    '{8'h01, 1'b0, 1'b0},  // filler in the middle of a message
    '{8'h7e, 1'b1, 1'b0},
    '{8'h80, 1'b0, 1'b1},
    '{8'h00, 1'b1, 1'b1},  // empty messages back to back
    '{8'h00, 1'b1, 1'b1},
    '{8'haa, 1'b0, 1'b1},  // one-byte messages back to back
    '{8'h55, 1'b0, 1'b1}
  };

  // Knobs shared between the stimulus and the result sink.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;

  // Hash predictor state and the hashes still owed by the block, oldest first.
  logic [63:0] msg_state = FNV_OFFSET_BASIS;
  logic [63:0] pending_hashes [$];
  int unsigned items_taken = 0;
  int unsigned errors = 0;

  byte_stream_fnv_fmix_hasher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_no_byte        (in_no_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hash_value    (out_hash_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Seeded fmix64: xor in the seed, then xor-shift / multiply / xor-shift /
  // multiply / xor-shift, all modulo 2^64.
  function automatic logic [63:0] fmix_seeded(input logic [63:0] h);
    logic [63:0] v;
    v = h ^ MIX_SEED;
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_MUL_A;
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_MUL_B;
    v = v ^ (v >> MIX_SHIFT);
    return v;
  endfunction

  // Advance the running FNV-1a state by one accepted transfer; on the end mark,
  // queue the finished hash and restart from the offset basis.
  task automatic absorb_item(input logic [7:0] b, input logic nb, input logic eom);
    if (!nb) begin
      msg_state = (msg_state ^ {56'd0, b}) * FNV_PRIME;
    end
    if (eom) begin
      pending_hashes.push_back(fmix_seeded(msg_state));
      msg_state = FNV_OFFSET_BASIS;
    end
    items_taken++;
  endtask

  // Offer one transfer and hold it until the block takes it. An idle gap,
  // if any, comes first, so valid never drops while an item is pending.
  task automatic drive_item(input logic [7:0] b, input logic nb, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_no_byte        <= nb;
    in_end_of_message <= eom;
    // Values read right after the edge are the ones the block saw at it.
    do @(posedge clk); while (!in_ready);
    absorb_item(b, nb, eom);
  endtask

  // Send one message of len bytes with random content. Sprinkle byteless
  // filler in; end either on the last byte or on a separate byteless item.
  task automatic send_message(input int unsigned len, input bit byteless_end);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        drive_item(8'($urandom), 1'b1, 1'b0);
      end
      drive_item(8'($urandom), 1'b0, (i == len - 1) && !byteless_end);
    end
    if (byteless_end || len == 0) begin
      drive_item(8'($urandom), 1'b1, 1'b1);
    end
  endtask

  // Drop valid and hold off until every queued hash has come out; advance at
  // least one edge so the next drive starts in a fresh time step.
  task automatic wait_all_hashes();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_hashes.size() != 0);
  endtask

  // Mostly well-formed messages of random length and content; the rest is
  // stray filler and fully random transfers.
  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input bit long_hold);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len_pick;
    int unsigned len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_taken + PHASE_ITEMS;
    // Starve the output for a while; keep offering bytes so the block fills
    // up and drops in_ready.
    if (long_hold) begin
      hold_request = LONG_HOLD_CYCLES;
    end
    while (items_taken < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        len_pick = $urandom_range(99);
        if (len_pick < 70) begin
          len = $urandom_range(6);
        end else if (len_pick < 95) begin
          len = $urandom_range(24, 7);
        end else begin
          len = $urandom_range(64, 25);
        end
        send_message(len, $urandom_range(3) == 0);
      end else if (pick < 93) begin
        drive_item(8'($urandom), 1'b1, 1'b0);
      end else begin
        drive_item(8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    wait_all_hashes();
  endtask

  // Result sink: check every output transfer against the oldest queued hash,
  // then pick out_ready for the next cycle. A long hold is counted here.
  initial begin : result_sink
    int unsigned hold_left;
    logic [63:0] want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_hashes.size() == 0) begin
          $display("%0t: hash with nothing queued, expected none, actual %h",
                   $time, out_hash_value);
          errors++;
        end else begin
          want = pending_hashes.pop_front();
          if (out_hash_value !== want) begin
            $display("%0t: hash_value mismatch, expected %h, actual %h",
                     $time, want, out_hash_value);
            errors++;
          end
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling on either side.
    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].data, directed_rows[i].no_byte, directed_rows[i].eom);
    end
    wait_all_hashes();

    // Random part: no idling (with a long output hold), sender idle,
    // receiver stalling, then both.
    run_random_phase(0, 0, 1'b1);
    run_random_phase(75, 0, 1'b0);
    run_random_phase(0, 75, 1'b0);
    run_random_phase(17, 17, 1'b0);

    // Keep the output open and give any stray hash time to show up.
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending_hashes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
